### hw/rtl/rv32i_execute_unit_top_macros.svh
// Assertion macros shared by the execute unit RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef RV32I_EXECUTE_UNIT_TOP_MACROS_SVH
`define RV32I_EXECUTE_UNIT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RV32EU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RV32EU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rv32eu_pkg.sv
// Shared types and constants for the RV32I execute unit.
// No dependencies; used by rv32i_execute_unit_top.
package rv32eu_pkg;

   localparam int XLEN        = 32;
   localparam int REG_COUNT   = 32;
   localparam int REG_AW      = $clog2(REG_COUNT);
   localparam int CMD_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int LANES       = XLEN / BYTE_W;
   localparam int LANE_AW     = $clog2(LANES);
   localparam int DATA_WORDS  = 1024;
   localparam int DATA_AW     = $clog2(DATA_WORDS);
   localparam int UPPER_SHIFT = 12;
   localparam int INSTR_BYTES = 4;
   localparam int SIZE_W      = 3;

   localparam logic [XLEN:0]       DATA_BYTES     = (XLEN + 1)'(DATA_WORDS * LANES);
   localparam logic [XLEN-1:0]     START_PC_RESET = '0;
   localparam logic [REG_AW-1:0]   REG_ZERO       = REG_AW'(0);
   localparam logic [REG_AW-1:0]   REG_A0         = REG_AW'(10);
   localparam logic [REG_AW-1:0]   REG_A1         = REG_AW'(11);
   localparam logic [SIZE_W-1:0]   SIZE_BYTE      = SIZE_W'(1);
   localparam logic [SIZE_W-1:0]   SIZE_HALF      = SIZE_W'(2);
   localparam logic [SIZE_W-1:0]   SIZE_WORD      = SIZE_W'(4);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 6'd0,  CMD_SUB   = 6'd1,  CMD_XOR   = 6'd2,  CMD_OR    = 6'd3,
      CMD_AND   = 6'd4,  CMD_SLL   = 6'd5,  CMD_SRL   = 6'd6,  CMD_SRA   = 6'd7,
      CMD_SLT   = 6'd8,  CMD_SLTU  = 6'd9,  CMD_ADDI  = 6'd10, CMD_XORI  = 6'd11,
      CMD_ORI   = 6'd12, CMD_ANDI  = 6'd13, CMD_SLLI  = 6'd14, CMD_SRLI  = 6'd15,
      CMD_SRAI  = 6'd16, CMD_SLTI  = 6'd17, CMD_SLTIU = 6'd18, CMD_LB    = 6'd19,
      CMD_LH    = 6'd20, CMD_LW    = 6'd21, CMD_LBU   = 6'd22, CMD_LHU   = 6'd23,
      CMD_SB    = 6'd24, CMD_SH    = 6'd25, CMD_SW    = 6'd26, CMD_BEQ   = 6'd27,
      CMD_BNE   = 6'd28, CMD_BLT   = 6'd29, CMD_BGE   = 6'd30, CMD_BLTU  = 6'd31,
      CMD_BGEU  = 6'd32, CMD_JAL   = 6'd33, CMD_JALR  = 6'd34, CMD_LUI   = 6'd35,
      CMD_AUIPC = 6'd36, CMD_ECALL = 6'd37
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [REG_AW-1:0] rd;
      logic [REG_AW-1:0] ra;
      logic [REG_AW-1:0] rb;
      logic [XLEN-1:0]   imm;
   } ex_type;

   typedef struct packed {
      logic              we;
      logic [REG_AW-1:0] idx;
      logic [XLEN-1:0]   val;
   } rf_wr_type;

   typedef struct packed {
      logic               wr;
      logic [REG_AW-1:0]  rd;
      logic [LANE_AW-1:0] off;
      logic [SIZE_W-1:0]  size;
      logic               sext;
      logic [XLEN-1:0]    npc;
   } ld_type;

   typedef struct packed {
      logic [XLEN-1:0]   next_pc;
      logic              reg_write;
      logic [REG_AW-1:0] reg_index;
      logic [XLEN-1:0]   reg_value;
      logic              taken;
      logic              env_call;
      logic [XLEN-1:0]   call_id;
      logic [XLEN-1:0]   call_arg;
      logic              status;
   } rsp_type;

endpackage

### hw/rtl/rv32eu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; instantiated for the register file and data store lanes.
module rv32eu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/rv32i_execute_unit_top.sv
// A result passes the execute and output registers; an in-range load also passes the
// load register. Throughput: one instruction per cycle while rsp_ready is high; an
// in-range load holds the input while its data store read completes. The output register
// keeps the next word moving. Reset: synchronous; pc takes zero, register file reads zero
// through valid bits, and the DATA_WORDS (1024) store rows are cleared with req_ready low.
// Depends on rv32eu_pkg, rv32eu_ram and rv32i_execute_unit_top_macros.svh.
`include "rv32i_execute_unit_top_macros.svh"

module rv32i_execute_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_command,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_reg_a,
   input  logic [4:0]  req_src_reg_b,
   input  logic signed [31:0] req_immediate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_taken,
   output logic        rsp_env_call,
   output logic [31:0] rsp_call_id,
   output logic [31:0] rsp_call_arg,
   output logic        rsp_status,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int XLEN    = rv32eu_pkg::XLEN;
   localparam int REG_AW  = rv32eu_pkg::REG_AW;
   localparam int DATA_AW = rv32eu_pkg::DATA_AW;
   localparam int LANES   = rv32eu_pkg::LANES;
   localparam int LANE_AW = rv32eu_pkg::LANE_AW;
   localparam int BYTE_W  = rv32eu_pkg::BYTE_W;
   localparam int SIZE_W  = rv32eu_pkg::SIZE_W;

   logic req_fire;
   logic out_free;
   logic out_load;

   logic               clr_busy_ff, clr_busy_in;
   logic [DATA_AW-1:0] clr_idx_ff, clr_idx_in;

   logic               ex_valid_ff, ex_valid_in;
   rv32eu_pkg::ex_type ex_ff, ex_in;
   logic               ex_go, ex_to_ld, ex_out;

   logic [rv32eu_pkg::REG_COUNT-1:0] rf_valid_ff, rf_valid_in;
   logic                  va_ff, va_in, vb_ff, vb_in;
   rv32eu_pkg::rf_wr_type fwd_ff, fwd_in, rf_wr;
   logic [REG_AW-1:0]     rd_addr_a, rd_addr_b;
   logic [XLEN-1:0]       rf_qa, rf_qb;

   logic [XLEN-1:0] pc_ff, pc_in;

   logic               ld_valid_ff, ld_valid_in;
   rv32eu_pkg::ld_type ld_ff, ld_in;
   logic               ld_done;
   logic [BYTE_W-1:0]  ld_byte [LANES];
   logic [XLEN-1:0]    ld_raw, ld_val;

   logic                rsp_valid_ff, rsp_valid_in;
   rv32eu_pkg::rsp_type rsp_ff, rsp_in;

   logic [XLEN-1:0]    op_a, op_b, imm, sum_ai, pc_plus4, pc_imm, val, npc;
   logic               wr, ex_wr, taken, ecall, cond, is_load, is_store, sext;
   logic [SIZE_W-1:0]  mem_size;
   logic [XLEN:0]      end_addr;
   logic               in_range, mem_bad;
   logic [LANE_AW-1:0] mem_off;
   logic [DATA_AW-1:0] mem_row;

   logic [LANES-1:0]  dm_we, dm_re;
   logic [BYTE_W-1:0] dm_q [LANES];

   // Handshake and pipeline flow.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ld_done  = ld_valid_ff && out_free;
   assign ex_to_ld = is_load && in_range;
   assign ex_go    = ex_valid_ff && (ex_to_ld || out_free);
   assign ex_out   = ex_go && !ex_to_ld;
   assign out_load = ld_done || ex_out;
   assign req_ready = !clr_busy_ff && (!ex_valid_ff || ex_out) && (!ld_valid_ff || ld_done);
   assign req_fire  = req_valid && req_ready;

   // Register file: two copies give two read ports; ECALL reads a0 and a1.
   always_comb begin
      rd_addr_a = req_src_reg_a;
      rd_addr_b = req_src_reg_b;
      if (req_command == rv32eu_pkg::CMD_ECALL) begin
         rd_addr_a = rv32eu_pkg::REG_A0;
         rd_addr_b = rv32eu_pkg::REG_A1;
      end
   end

   rv32eu_ram #(.WIDTH(XLEN), .DEPTH(rv32eu_pkg::REG_COUNT)) u_rf_a (
      .clock (clock),
      .we    (rf_wr.we),
      .waddr (rf_wr.idx),
      .wdata (rf_wr.val),
      .re    (req_fire),
      .raddr (rd_addr_a),
      .rdata (rf_qa)
   );

   rv32eu_ram #(.WIDTH(XLEN), .DEPTH(rv32eu_pkg::REG_COUNT)) u_rf_b (
      .clock (clock),
      .we    (rf_wr.we),
      .waddr (rf_wr.idx),
      .wdata (rf_wr.val),
      .re    (req_fire),
      .raddr (rd_addr_b),
      .rdata (rf_qb)
   );

   // A write in the read cycle is forwarded; an entry never written reads zero.
   assign op_a = (fwd_ff.we && fwd_ff.idx == ex_ff.ra) ? fwd_ff.val : (va_ff ? rf_qa : '0);
   assign op_b = (fwd_ff.we && fwd_ff.idx == ex_ff.rb) ? fwd_ff.val : (vb_ff ? rf_qb : '0);

   assign imm      = ex_ff.imm;
   assign sum_ai   = op_a + imm;
   assign pc_plus4 = pc_ff + XLEN'(rv32eu_pkg::INSTR_BYTES);
   assign pc_imm   = pc_ff + imm;

   always_comb begin
      val      = '0;
      wr       = 1'b0;
      taken    = 1'b0;
      ecall    = 1'b0;
      cond     = 1'b0;
      is_load  = 1'b0;
      is_store = 1'b0;
      sext     = 1'b0;
      mem_size = rv32eu_pkg::SIZE_WORD;
      npc      = pc_plus4;
      unique case (ex_ff.cmd) inside
         rv32eu_pkg::CMD_ADD:   begin val = op_a + op_b; wr = 1'b1; end
         rv32eu_pkg::CMD_SUB:   begin val = op_a - op_b; wr = 1'b1; end
         rv32eu_pkg::CMD_XOR:   begin val = op_a ^ op_b; wr = 1'b1; end
         rv32eu_pkg::CMD_OR:    begin val = op_a | op_b; wr = 1'b1; end
         rv32eu_pkg::CMD_AND:   begin val = op_a & op_b; wr = 1'b1; end
         rv32eu_pkg::CMD_SLL:   begin val = op_a << op_b[4:0]; wr = 1'b1; end
         rv32eu_pkg::CMD_SRL:   begin val = op_a >> op_b[4:0]; wr = 1'b1; end
         rv32eu_pkg::CMD_SRA:   begin val = $signed(op_a) >>> op_b[4:0]; wr = 1'b1; end
         rv32eu_pkg::CMD_SLT:   begin
            val = XLEN'($signed(op_a) < $signed(op_b));
            wr  = 1'b1;
         end
         rv32eu_pkg::CMD_SLTU:  begin val = XLEN'(op_a < op_b); wr = 1'b1; end
         rv32eu_pkg::CMD_ADDI:  begin val = sum_ai; wr = 1'b1; end
         rv32eu_pkg::CMD_XORI:  begin val = op_a ^ imm; wr = 1'b1; end
         rv32eu_pkg::CMD_ORI:   begin val = op_a | imm; wr = 1'b1; end
         rv32eu_pkg::CMD_ANDI:  begin val = op_a & imm; wr = 1'b1; end
         rv32eu_pkg::CMD_SLLI:  begin val = op_a << imm[4:0]; wr = 1'b1; end
         rv32eu_pkg::CMD_SRLI:  begin val = op_a >> imm[4:0]; wr = 1'b1; end
         rv32eu_pkg::CMD_SRAI:  begin val = $signed(op_a) >>> imm[4:0]; wr = 1'b1; end
         rv32eu_pkg::CMD_SLTI:  begin
            val = XLEN'($signed(op_a) < $signed(imm));
            wr  = 1'b1;
         end
         rv32eu_pkg::CMD_SLTIU: begin val = XLEN'(op_a < imm); wr = 1'b1; end
         rv32eu_pkg::CMD_LB:    begin
            is_load = 1'b1; mem_size = rv32eu_pkg::SIZE_BYTE; sext = 1'b1;
         end
         rv32eu_pkg::CMD_LH:    begin
            is_load = 1'b1; mem_size = rv32eu_pkg::SIZE_HALF; sext = 1'b1;
         end
         rv32eu_pkg::CMD_LW:    begin is_load = 1'b1; end
         rv32eu_pkg::CMD_LBU:   begin is_load = 1'b1; mem_size = rv32eu_pkg::SIZE_BYTE; end
         rv32eu_pkg::CMD_LHU:   begin is_load = 1'b1; mem_size = rv32eu_pkg::SIZE_HALF; end
         rv32eu_pkg::CMD_SB:    begin is_store = 1'b1; mem_size = rv32eu_pkg::SIZE_BYTE; end
         rv32eu_pkg::CMD_SH:    begin is_store = 1'b1; mem_size = rv32eu_pkg::SIZE_HALF; end
         rv32eu_pkg::CMD_SW:    begin is_store = 1'b1; end
         rv32eu_pkg::CMD_BEQ:   begin cond = (op_a == op_b); end
         rv32eu_pkg::CMD_BNE:   begin cond = (op_a != op_b); end
         rv32eu_pkg::CMD_BLT:   begin cond = ($signed(op_a) < $signed(op_b)); end
         rv32eu_pkg::CMD_BGE:   begin cond = !($signed(op_a) < $signed(op_b)); end
         rv32eu_pkg::CMD_BLTU:  begin cond = (op_a < op_b); end
         rv32eu_pkg::CMD_BGEU:  begin cond = (op_a >= op_b); end
         rv32eu_pkg::CMD_JAL:   begin
            val = pc_plus4; wr = 1'b1; taken = 1'b1; npc = pc_imm;
         end
         rv32eu_pkg::CMD_JALR:  begin
            val = pc_plus4; wr = 1'b1; taken = 1'b1; npc = {sum_ai[XLEN-1:1], 1'b0};
         end
         rv32eu_pkg::CMD_LUI:   begin val = imm << rv32eu_pkg::UPPER_SHIFT; wr = 1'b1; end
         rv32eu_pkg::CMD_AUIPC: begin
            val = pc_ff + (imm << rv32eu_pkg::UPPER_SHIFT);
            wr  = 1'b1;
         end
         rv32eu_pkg::CMD_ECALL: begin ecall = 1'b1; end
         default: begin end
      endcase
      if (cond) begin
         taken = 1'b1;
         npc   = pc_imm;
      end
   end

   assign ex_wr = wr && (ex_ff.rd != rv32eu_pkg::REG_ZERO);

   // Data store: one byte-wide RAM per lane, so a misaligned access touches each
   // lane once, at the base row or the row after it.
   assign end_addr = {1'b0, sum_ai} + (XLEN + 1)'(mem_size);
   assign in_range = end_addr <= rv32eu_pkg::DATA_BYTES;
   assign mem_bad  = (is_load || is_store) && !in_range;
   assign mem_off  = sum_ai[LANE_AW-1:0];
   assign mem_row  = sum_ai[DATA_AW+LANE_AW-1:LANE_AW];

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [LANE_AW-1:0] k;
      logic               hit;
      logic [DATA_AW-1:0] row;
      logic [DATA_AW-1:0] waddr;
      logic [XLEN-1:0]    sh_b;
      logic [BYTE_W-1:0]  wdata;

      assign k     = LANE_AW'(j) - mem_off;
      assign hit   = SIZE_W'(k) < mem_size;
      assign row   = mem_row + DATA_AW'(LANE_AW'(j) < mem_off);
      assign sh_b  = op_b >> {k, 3'b000};
      assign waddr = clr_busy_ff ? clr_idx_ff : row;
      assign wdata = clr_busy_ff ? '0 : sh_b[BYTE_W-1:0];
      assign dm_we[j] = clr_busy_ff || (ex_out && is_store && in_range && hit);
      assign dm_re[j] = ex_go && ex_to_ld;

      rv32eu_ram #(.WIDTH(BYTE_W), .DEPTH(rv32eu_pkg::DATA_WORDS)) u_ram (
         .clock (clock),
         .we    (dm_we[j]),
         .waddr (waddr),
         .wdata (wdata),
         .re    (dm_re[j]),
         .raddr (row),
         .rdata (dm_q[j])
      );

      assign ld_byte[j] = (SIZE_W'(j) < ld_ff.size) ? dm_q[LANE_AW'(j) + ld_ff.off] : '0;
   end

   assign ld_raw = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};

   always_comb begin
      ld_val = ld_raw;
      if (ld_ff.sext && ld_ff.size == rv32eu_pkg::SIZE_BYTE && ld_raw[7]) begin
         ld_val[XLEN-1:8] = '1;
      end
      if (ld_ff.sext && ld_ff.size == rv32eu_pkg::SIZE_HALF && ld_raw[15]) begin
         ld_val[XLEN-1:16] = '1;
      end
   end

   always_comb begin
      rf_wr.we  = ex_out && ex_wr;
      rf_wr.idx = ex_ff.rd;
      rf_wr.val = val;
      if (ld_done) begin
         rf_wr.we  = ld_ff.wr;
         rf_wr.idx = ld_ff.rd;
         rf_wr.val = ld_val;
      end
   end

   // Next-state logic.
   always_comb begin
      clr_busy_in = clr_busy_ff && (clr_idx_ff != DATA_AW'(rv32eu_pkg::DATA_WORDS - 1));
      clr_idx_in  = clr_busy_ff ? clr_idx_ff + DATA_AW'(1) : clr_idx_ff;

      ex_valid_in = req_fire || (ex_valid_ff && !ex_go);
      ex_in       = ex_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      fwd_in      = fwd_ff;
      if (req_fire) begin
         ex_in.cmd = req_command;
         ex_in.rd  = req_dest_reg;
         ex_in.ra  = rd_addr_a;
         ex_in.rb  = rd_addr_b;
         ex_in.imm = req_immediate;
         va_in     = rf_valid_ff[rd_addr_a];
         vb_in     = rf_valid_ff[rd_addr_b];
         fwd_in    = rf_wr;
      end

      rf_valid_in = rf_valid_ff;
      if (rf_wr.we) begin
         rf_valid_in[rf_wr.idx] = 1'b1;
      end

      pc_in = pc_ff;
      if (csr_we) begin
         pc_in = csr_wdata;
      end else if (ex_go) begin
         pc_in = npc;
      end

      ld_valid_in = (ex_go && ex_to_ld) || (ld_valid_ff && !ld_done);
      ld_in       = ld_ff;
      if (ex_go && ex_to_ld) begin
         ld_in.wr   = ex_ff.rd != rv32eu_pkg::REG_ZERO;
         ld_in.rd   = ex_ff.rd;
         ld_in.off  = mem_off;
         ld_in.size = mem_size;
         ld_in.sext = sext;
         ld_in.npc  = npc;
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (ld_done) begin
         rsp_in.next_pc   = ld_ff.npc;
         rsp_in.reg_write = ld_ff.wr;
         rsp_in.reg_index = ld_ff.wr ? ld_ff.rd : '0;
         rsp_in.reg_value = ld_ff.wr ? ld_val : '0;
         rsp_in.taken     = 1'b0;
         rsp_in.env_call  = 1'b0;
         rsp_in.call_id   = '0;
         rsp_in.call_arg  = '0;
         rsp_in.status    = 1'b0;
      end else if (ex_out) begin
         rsp_in.next_pc   = npc;
         rsp_in.reg_write = ex_wr;
         rsp_in.reg_index = ex_wr ? ex_ff.rd : '0;
         rsp_in.reg_value = ex_wr ? val : '0;
         rsp_in.taken     = taken;
         rsp_in.env_call  = ecall;
         rsp_in.call_id   = ecall ? op_a : '0;
         rsp_in.call_arg  = ecall ? op_b : '0;
         rsp_in.status    = mem_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         ex_valid_ff  <= 1'b0;
         ld_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
         pc_ff        <= rv32eu_pkg::START_PC_RESET;
         fwd_ff.we    <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         ex_valid_ff  <= ex_valid_in;
         ld_valid_ff  <= ld_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
         pc_ff        <= pc_in;
         fwd_ff.we    <= fwd_in.we;
      end
   end

   always_ff @(posedge clock) begin
      ex_ff      <= ex_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      fwd_ff.idx <= fwd_in.idx;
      fwd_ff.val <= fwd_in.val;
      ld_ff      <= ld_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_ff.next_pc;
   assign rsp_reg_write = rsp_ff.reg_write;
   assign rsp_reg_index = rsp_ff.reg_index;
   assign rsp_reg_value = rsp_ff.reg_value;
   assign rsp_taken     = rsp_ff.taken;
   assign rsp_env_call  = rsp_ff.env_call;
   assign rsp_call_id   = rsp_ff.call_id;
   assign rsp_call_arg  = rsp_ff.call_arg;
   assign rsp_status    = rsp_ff.status;

   `RV32EU_ASSERT_SAME(a_stage_excl, clock, reset, ex_valid_ff, !ld_valid_ff, "execute and load stages both hold an instruction")
   `RV32EU_ASSERT_SAME(a_clear_blocks, clock, reset, clr_busy_ff, !req_ready, "word accepted during data store clear")
   `RV32EU_ASSERT_SAME(a_no_x0_write, clock, reset, rf_wr.we, rf_wr.idx != rv32eu_pkg::REG_ZERO, "register x0 written")
   `RV32EU_ASSERT_NEXT(a_load_moves, clock, reset, ex_go && ex_to_ld, ld_valid_ff && !ex_valid_ff, "load did not move alone into the load stage")

endmodule
